### rtl/abelian_square_suffix_check_unit_assert.svh
// assertion macros for the abelian square suffix checker
`ifndef ABELIAN_SQUARE_SUFFIX_CHECK_UNIT_ASSERT_SVH
`define ABELIAN_SQUARE_SUFFIX_CHECK_UNIT_ASSERT_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define ASCU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ascu: property violated");
// condition must never be seen outside reset
`define ASCU_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("ascu: forbidden condition seen");
`else
`define ASCU_ASSERT(lbl, clk, rst_n, prop)
`define ASCU_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

### rtl/ascu_pkg.sv
package ascu_pkg;

  // alphabet and field widths
  localparam int LETTERS     = 3;
  localparam int SYM_W       = 2;
  localparam int HALF_W      = 7;
  localparam int LEN_W       = 8;
  localparam int CNT_W       = 8;
  localparam int CNTS_W      = LETTERS * CNT_W;
  localparam int MAX_LEN_DEF = 128;

  // reset value of the minimum half length register
  localparam logic [HALF_W-1:0] MIN_HALF_RST = HALF_W'(2);

  // per-letter prefix counts
  typedef logic [LETTERS-1:0][CNT_W-1:0] counts_t;

endpackage

### rtl/ascu_ifs.sv
// input channel: one letter per item
interface ascu_in_if;
  import ascu_pkg::*;
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             restart;
  modport source (output valid, symbol, restart, input ready);
  modport sink   (input valid, symbol, restart, output ready);
endinterface

// result channel: one result per item
interface ascu_out_if;
  import ascu_pkg::*;
  logic              valid;
  logic              ready;
  logic              accepted;
  logic              square_found;
  logic [HALF_W-1:0] half_length;
  logic [LEN_W-1:0]  word_length;
  modport source (output valid, accepted, square_found, half_length, word_length,
                  input ready);
  modport sink   (input valid, accepted, square_found, half_length, word_length,
                  output ready);
endinterface

### rtl/ascu_ram.sv
module ascu_ram #(
  parameter int WIDTH = ascu_pkg::CNTS_W,
  parameter int DEPTH = ascu_pkg::MAX_LEN_DEF + 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

### rtl/abelian_square_suffix_check_unit.sv
// Abelian square suffix checker over the letters a, b and c. Each input item
// appends one letter (or first empties the word when restart is set) and
// yields one result: whether the word now ends in a suffix of length 2k whose
// halves hold equal letter counts, for k from the configured minimum upward,
// and the smallest such k. Prefix counts live in a two-read-port RAM; one
// candidate half length is read and compared per cycle, and an appended letter
// is searched until the first match or the end of the range (at most word
// length / 2 - min + 1 half lengths) before the next item is accepted. A
// refused letter goes straight to the result. A finished result waits in the
// output register while the next item is accepted. The user must write the
// minimum half length only while the block is idle; the block itself does not
// enforce this. Zero acts as one.
module abelian_square_suffix_check_unit #(
  parameter int MAX_LEN = ascu_pkg::MAX_LEN_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ascu_in_if.sink                     in_i,
  ascu_out_if.source                  out_o,
  input  logic                        cfg_we_i,
  input  logic [ascu_pkg::HALF_W-1:0] cfg_wdata_i
);
  import ascu_pkg::*;

  `include "abelian_square_suffix_check_unit_assert.svh"

  localparam int AW = $clog2(MAX_LEN + 1);
  localparam logic [LEN_W-1:0] MAX_LEN_L = LEN_W'(MAX_LEN);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SRCH = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [HALF_W-1:0] min_q;
  logic [LEN_W-1:0]  len_q, len_d;
  counts_t           cur_q, cur_d;
  logic [LEN_W-1:0]  k_q, k_d;
  logic              p_valid_q, p_valid_d;
  logic              pz_a_q, pz_b_q;
  logic [LEN_W-1:0]  pk_q;
  logic              res_acc_q, res_acc_d;
  logic              res_found_q, res_found_d;
  logic [HALF_W-1:0] res_half_q, res_half_d;
  logic              out_valid_q, out_valid_d;
  logic              out_acc_q, out_found_q;
  logic [HALF_W-1:0] out_half_q;
  logic [LEN_W-1:0]  out_len_q;
  logic              out_load;

  logic              in_fire;
  logic [LEN_W-1:0]  len_eff;
  counts_t           cur_eff, cur_inc;
  logic              sym_ok;
  logic [LEN_W-1:0]  kmin;

  logic              issue;
  logic [LEN_W-1:0]  addr_a, addr_b;
  logic              ram_we;
  logic [LEN_W-1:0]  waddr;
  logic [CNTS_W-1:0] rd_a_raw, rd_b_raw;
  counts_t           rd_a, rd_b;
  logic              match;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MIN_HALF_RST;
    end else if (cfg_we_i) begin
      min_q <= cfg_wdata_i;
    end
  end

  assign kmin = (min_q == '0) ? LEN_W'(1) : LEN_W'(min_q);

  // input side
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign len_eff    = in_i.restart ? '0 : len_q;
  assign cur_eff    = in_i.restart ? '0 : cur_q;
  assign sym_ok     = (len_eff < MAX_LEN_L) && (in_i.symbol < SYM_W'(LETTERS));

  // counts after the new letter
  always_comb begin
    for (int c = 0; c < LETTERS; c++) begin
      cur_inc[c] = cur_eff[c] + CNT_W'(in_i.symbol == SYM_W'(c));
    end
  end

  // candidate addresses for the current half length
  assign issue  = ({k_q, 1'b0} <= {1'b0, len_q});
  assign addr_a = len_q - k_q;
  assign addr_b = len_q - {k_q[LEN_W-2:0], 1'b0};

  assign ram_we = in_fire && sym_ok;
  assign waddr  = len_eff + LEN_W'(1);

  ascu_ram #(
    .WIDTH (CNTS_W),
    .DEPTH (MAX_LEN + 1)
  ) u_prefix_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (waddr[AW-1:0]),
    .wdata_i   (cur_inc),
    .raddr_a_i (addr_a[AW-1:0]),
    .raddr_b_i (addr_b[AW-1:0]),
    .rdata_a_o (rd_a_raw),
    .rdata_b_o (rd_b_raw)
  );

  // entry zero is the empty prefix and always reads as zero
  assign rd_a = pz_a_q ? '0 : counts_t'(rd_a_raw);
  assign rd_b = pz_b_q ? '0 : counts_t'(rd_b_raw);

  // shared compare unit: halves equal when 2*mid == start + end per letter
  always_comb begin
    match = 1'b1;
    for (int c = 0; c < LETTERS; c++) begin
      if ({rd_a[c], 1'b0} != ({1'b0, rd_b[c]} + {1'b0, cur_q[c]})) begin
        match = 1'b0;
      end
    end
  end

  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  // sequencer
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    cur_d       = cur_q;
    k_d         = k_q;
    p_valid_d   = 1'b0;
    res_acc_d   = res_acc_q;
    res_found_d = res_found_q;
    res_half_d  = res_half_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_found_d = 1'b0;
          res_half_d  = '0;
          if (sym_ok) begin
            len_d     = len_eff + LEN_W'(1);
            cur_d     = cur_inc;
            k_d       = kmin;
            res_acc_d = 1'b1;
            state_d   = S_SRCH;
          end else begin
            len_d     = len_eff;
            cur_d     = cur_eff;
            res_acc_d = 1'b0;
            state_d   = S_DONE;
          end
        end
      end
      S_SRCH: begin
        if (p_valid_q && match) begin
          res_found_d = 1'b1;
          res_half_d  = pk_q[HALF_W-1:0];
          state_d     = S_DONE;
        end else if (!issue) begin
          state_d = S_DONE;
        end else begin
          p_valid_d = 1'b1;
          k_d       = k_q + LEN_W'(1);
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      cur_q       <= '0;
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      cur_q       <= cur_d;
      p_valid_q   <= p_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // search datapath and result registers
  always_ff @(posedge clk_i) begin
    k_q         <= k_d;
    pk_q        <= k_q;
    pz_a_q      <= (addr_a == '0);
    pz_b_q      <= (addr_b == '0);
    res_acc_q   <= res_acc_d;
    res_found_q <= res_found_d;
    res_half_q  <= res_half_d;
    if (out_load) begin
      out_acc_q   <= res_acc_q;
      out_found_q <= res_found_q;
      out_half_q  <= res_half_q;
      out_len_q   <= len_q;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.accepted     = out_acc_q;
  assign out_o.square_found = out_found_q;
  assign out_o.half_length  = out_half_q;
  assign out_o.word_length  = out_len_q;

  // checks
  `ASCU_ASSERT(a_half_iff_found, clk_i, rst_ni, out_valid_q |-> (out_found_q == (out_half_q != '0)))
  `ASCU_ASSERT(a_square_fits, clk_i, rst_ni, (out_valid_q && out_found_q) |-> ({1'b0, out_half_q, 1'b0} <= {1'b0, out_len_q}))
  `ASCU_ASSERT(a_append_searches, clk_i, rst_ni, (in_fire && sym_ok) |=> (state_q == S_SRCH))
  `ASCU_NEVER(a_len_bound, clk_i, rst_ni, len_q > MAX_LEN_L)

endmodule

### dv/tb_abelian_square_suffix_check_unit.sv
`timescale 1ns / 100ps

module tb_abelian_square_suffix_check_unit;
  import ascu_pkg::*;

  localparam int WORD_MAX       = MAX_LEN_DEF;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES         = 8;
  localparam int PHASE_LETTERS  = 145;

  typedef enum logic [SYM_W-1:0] {
    LET_A    = 2'd0,
    LET_B    = 2'd1,
    LET_C    = 2'd2,
    LET_NONE = 2'd3
  } letter_e;

  typedef struct packed {
    logic              accepted;
    logic              square_found;
    logic [HALF_W-1:0] half_length;
    logic [LEN_W-1:0]  word_length;
  } result_t;

  typedef struct packed {
    letter_e sym;
    logic    restart;
    logic    pinned;
    result_t want;
  } dir_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [HALF_W-1:0] cfg_wdata_i = '0;

  ascu_in_if  in_if ();
  ascu_out_if out_if ();

  abelian_square_suffix_check_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // shadow copy of the word state
  counts_t           prefix_tab [0:WORD_MAX];
  int                word_len = 0;
  logic [HALF_W-1:0] min_half = MIN_HALF_RST;

  result_t pending_results [$];
  int      fail_cnt = 0;
  int      mismatch_cnt = 0;
  int      quiet_cycles = 0;
  int      src_idle_pct = 0;
  int      stall_pct = 0;
  int      hold_asks = 0;
  int      hold_served = 0;
  int      hold_left = 0;

  // append one letter and look for the shortest abelian square ending the word
  function automatic result_t square_search_step(letter_e sym, logic restart);
    result_t r;
    int      kmin;
    int      first;
    int      second;
    logic    same;
    r = '0;
    if (restart) begin
      word_len = 0;
      prefix_tab[0] = '0;
    end
    if (word_len < WORD_MAX && sym != LET_NONE) begin
      for (int c = 0; c < LETTERS; c++) begin
        prefix_tab[word_len + 1][c] = prefix_tab[word_len][c] + CNT_W'(c == int'(sym));
      end
      word_len++;
      r.accepted = 1'b1;
      kmin = (min_half == 0) ? 1 : int'(min_half);
      for (int k = kmin; 2 * k <= word_len && !r.square_found; k++) begin
        same = 1'b1;
        for (int c = 0; c < LETTERS; c++) begin
          first  = int'(prefix_tab[word_len - k][c]) - int'(prefix_tab[word_len - 2 * k][c]);
          second = int'(prefix_tab[word_len][c]) - int'(prefix_tab[word_len - k][c]);
          if (first != second) same = 1'b0;
        end
        if (same) begin
          r.square_found = 1'b1;
          r.half_length  = HALF_W'(k);
        end
      end
    end
    r.word_length = LEN_W'(word_len);
    return r;
  endfunction

  // offer one item, wait for the handshake, then record what should come back
  task automatic send_item(input letter_e sym, input logic restart,
                           input logic pinned = 1'b0, input result_t want = '0);
    result_t predicted;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.symbol  <= sym;
    in_if.restart <= restart;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    predicted = square_search_step(sym, restart);
    pending_results = {pending_results, (pinned ? want : predicted)};
  endtask

  // drain everything in flight, then write the minimum half length
  task automatic settle_and_write_min(input logic [HALF_W-1:0] v);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    min_half = v;
  endtask

  // random prefix, then a random half followed by a shuffled copy of it
  function automatic void build_word(ref letter_e w[$], input int pre_len, input int half_len);
    letter_e half_q[$];
    letter_e tmp;
    int      j;
    w.delete();
    for (int i = 0; i < pre_len; i++) w = {w, letter_e'($urandom_range(0, 2))};
    for (int i = 0; i < half_len; i++) half_q = {half_q, letter_e'($urandom_range(0, 2))};
    w = {w, half_q};
    for (int i = half_len - 1; i > 0; i--) begin
      j         = $urandom_range(0, i);
      tmp       = half_q[i];
      half_q[i] = half_q[j];
      half_q[j] = tmp;
    end
    w = {w, half_q};
  endfunction

  // send a word with occasional refused letters and stray restarts mixed in;
  // a word longer than the maximum runs without stray restarts so it fills up
  task automatic send_word(ref letter_e w[$], input logic restart_first, ref int letters);
    logic restart;
    logic strays;
    strays = (w.size() <= WORD_MAX);
    foreach (w[i]) begin
      if ($urandom_range(0, 39) == 0) begin
        send_item(LET_NONE, strays && ($urandom_range(0, 3) == 0));
      end
      restart = (i == 0 && restart_first) || (strays && ($urandom_range(0, 59) == 0));
      send_item(w[i], restart);
      letters++;
    end
  endtask

  // receiver side: random stalls plus a long hold-off when one is asked for
  always @(posedge clk_i) begin
    if (hold_asks != hold_served) begin
      hold_served = hold_asks;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_if.accepted, out_if.square_found, out_if.half_length, out_if.word_length};
      if (pending_results.size() == 0) begin
        fail_cnt++;
        if (mismatch_cnt < 10) begin
          $display("unexpected result: acc=%0d sq=%0d half=%0d len=%0d",
                   got.accepted, got.square_found, got.half_length, got.word_length);
        end
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          fail_cnt++;
          if (mismatch_cnt < 10) begin
            $display({"mismatch: expected acc=%0d sq=%0d half=%0d len=%0d, ",
                      "got acc=%0d sq=%0d half=%0d len=%0d"},
                     want.accepted, want.square_found, want.half_length, want.word_length,
                     got.accepted, got.square_found, got.half_length, got.word_length);
          end
          mismatch_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    dir_row_t          dir_rows [20];
    logic [HALF_W-1:0] phase_min [PHASES];
    letter_e           word [$];
    int                letters;
    int                h;
    int                pick;

    in_if.valid   = 1'b0;
    in_if.symbol  = LET_A;
    in_if.restart = 1'b0;
    prefix_tab[0] = '0;

    // directed items, minimum half length still at its reset value
    dir_rows = '{
      '{LET_A,    1'b0, 1'b1, '{1'b1, 1'b0, 7'd0, 8'd1}},
      '{LET_NONE, 1'b0, 1'b1, '{1'b0, 1'b0, 7'd0, 8'd1}},
      '{LET_B,    1'b0, 1'b0, '0},
      '{LET_A,    1'b0, 1'b0, '0},
      '{LET_B,    1'b0, 1'b0, '0},
      '{LET_C,    1'b1, 1'b1, '{1'b1, 1'b0, 7'd0, 8'd1}},
      '{LET_NONE, 1'b1, 1'b1, '{1'b0, 1'b0, 7'd0, 8'd0}},
      '{LET_C,    1'b0, 1'b1, '{1'b1, 1'b0, 7'd0, 8'd1}},
      '{LET_C,    1'b0, 1'b0, '0},
      '{LET_C,    1'b0, 1'b0, '0},
      '{LET_C,    1'b0, 1'b0, '0},
      '{LET_A,    1'b1, 1'b0, '0},
      '{LET_B,    1'b0, 1'b0, '0},
      '{LET_C,    1'b0, 1'b0, '0},
      '{LET_C,    1'b0, 1'b0, '0},
      '{LET_B,    1'b0, 1'b0, '0},
      '{LET_A,    1'b0, 1'b0, '0},
      '{LET_NONE, 1'b0, 1'b1, '{1'b0, 1'b0, 7'd0, 8'd6}},
      '{LET_B,    1'b0, 1'b0, '0},
      '{LET_B,    1'b1, 1'b0, '0}
    };
    phase_min = '{7'd127, 7'd0, 7'd1, 7'd64, 7'd2, 7'd5, 7'd3,
                  HALF_W'($urandom_range(1, 64))};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].sym, dir_rows[i].restart, dir_rows[i].pinned, dir_rows[i].want);
    end

    // random phases, each setting a minimum and one of four idling patterns
    for (int p = 0; p < PHASES; p++) begin
      settle_and_write_min(phase_min[p]);
      case (p % 4)
        0: begin src_idle_pct = 0;  stall_pct = 0;  end
        1: begin src_idle_pct = 83; stall_pct = 0;  end
        2: begin src_idle_pct = 0;  stall_pct = 83; end
        default: begin src_idle_pct = 10; stall_pct = 10; end
      endcase
      if (p == 4) hold_asks++;
      letters = 0;

      // full-length word ending in a square, plus a few letters past the end
      if (p == 0 || p == 3 || p == 6) begin
        h = (p == 3) ? WORD_MAX / 2 : $urandom_range(1, WORD_MAX / 2);
        build_word(word, WORD_MAX - 2 * h, h);
        repeat ($urandom_range(1, 3)) word = {word, letter_e'($urandom_range(0, 2))};
        send_word(word, 1'b1, letters);
      end

      while (letters < PHASE_LETTERS) begin
        pick = $urandom_range(0, 9);
        if (pick <= 4) begin
          build_word(word, $urandom_range(1, 24), 0);
        end else if (pick <= 8) begin
          build_word(word, $urandom_range(0, 12), $urandom_range(1, 12));
        end else begin
          h = $urandom_range(8, 40);
          build_word(word, $urandom_range(0, 100 - 2 * h), h);
        end
        // now and then keep the old word so lengths pile up
        send_word(word, $urandom_range(0, 7) != 0, letters);
      end
    end

    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    fail_cnt += pending_results.size();
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/ascu_pkg.sv
rtl/ascu_ifs.sv
rtl/ascu_ram.sv
rtl/abelian_square_suffix_check_unit.sv
dv/tb_abelian_square_suffix_check_unit.sv
